FILE: design/qmi_pkg.sv
// ----------------------------------------------------------------------------
// qmi_pkg
// shared types and constants of the queue with middle insertion
// ----------------------------------------------------------------------------
package qmi_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int DATA_W           = 32;
    localparam int ACTION_W         = 2;
    localparam int STATUS_W         = 2;
    localparam int ENTRY_COUNT_W    = 7;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH_TAIL = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_MID  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP       = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // operations applied together to one ring
    typedef struct packed {
        logic take_head;
        logic push_tail;
        logic push_head;
    } ring_op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  popped_value;
        status_t                   status;
        logic [ENTRY_COUNT_W-1:0]  entry_count;
    } rsp_t;

endpackage

FILE: design/qmi_if.sv
// ----------------------------------------------------------------------------
// qmi_if
// command and response channels of the queue with middle insertion
// ----------------------------------------------------------------------------
interface qmi_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic [qmi_pkg::ACTION_W-1:0]           action;
    logic signed [qmi_pkg::DATA_W-1:0]      value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface qmi_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [qmi_pkg::DATA_W-1:0]      popped_value;
    qmi_pkg::status_t                       status;
    logic [qmi_pkg::ENTRY_COUNT_W-1:0]      entry_count;

    modport source (output valid, output popped_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input popped_value, input status, input entry_count,
                    output ready);
endinterface

FILE: design/qmi_ram.sv
// ----------------------------------------------------------------------------
// qmi_ram
// simple dual-port ram, one write and one registered read, read returns old data
// ----------------------------------------------------------------------------
module qmi_ram #(
    parameter int WIDTH = qmi_pkg::DATA_W,
    parameter int DEPTH = qmi_pkg::DEFAULT_CAPACITY
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/qmi_ring.sv
// ----------------------------------------------------------------------------
// qmi_ring
// ring buffer half-queue with head word kept visible every cycle
// ----------------------------------------------------------------------------
module qmi_ring #(
    parameter int CAPACITY = qmi_pkg::DEFAULT_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  qmi_pkg::ring_op_t                 op,
    input  logic [qmi_pkg::DATA_W-1:0]        wdata,
    output logic [qmi_pkg::DATA_W-1:0]        head_value,
    output logic [$clog2(CAPACITY+1)-1:0]     count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0]              head_reg;
    logic [AW-1:0]              head_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [AW-1:0]              head_inc;
    logic [AW-1:0]              head_dec;
    logic [SW-1:0]              tail_sum;
    logic [SW-1:0]              tail_wrap;
    logic [AW-1:0]              waddr;
    logic                       we;
    logic                       push;
    logic [qmi_pkg::DATA_W-1:0] ram_q;
    logic                       bypass_reg;
    logic [qmi_pkg::DATA_W-1:0] hold_reg;

    assign head_inc  = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec  = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - AW'(1);
    // tail slot is head + count, wrapped once
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_wrap = (tail_sum >= SW'(CAPACITY)) ? tail_sum - SW'(CAPACITY) : tail_sum;

    assign push  = op.push_tail | op.push_head;
    assign we    = push;
    assign waddr = op.push_head ? head_dec : tail_wrap[AW-1:0];

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (op.push_head)
        begin
            head_next = head_dec;
        end
        else if (op.take_head)
        begin
            head_next = head_inc;
        end
        if (push && !op.take_head)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.take_head && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            // ram returns the old word when the new head is written this cycle
            bypass_reg <= we && (waddr == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= wdata;
    end

    qmi_ram #(
        .WIDTH (qmi_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (head_next),
        .rdata (ram_q)
    );

    assign head_value = bypass_reg ? hold_reg : ram_q;
    assign count      = count_reg;

endmodule

FILE: design/queue_with_middle_insert.sv
// ----------------------------------------------------------------------------
// queue_with_middle_insert
// bounded fifo of signed words with push at tail, push at middle, pop at head
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------
//  cmd     | in  | valid / ready | action, value
//  rsp     | out | valid / ready | popped_value, status, entry_count
//
//  one word per cycle is taken on cmd while ready; its response shows on rsp
//  the next cycle unless rsp stalls; the rate is set by both ring pointers
//  updating together, each ring's head word read ahead from its ram and
//  bypassed when just written; reset empties both halves at once, no clearing
//  pass, ram contents are unused; a stalled rsp is absorbed by a one-word skid
//  stage; cmd ready drops only while that skid word is held
//
module queue_with_middle_insert #(
    parameter int CAPACITY = qmi_pkg::DEFAULT_CAPACITY
) (
    input logic            clk,
    input logic            rst_n,
    qmi_cmd_if.sink        cmd,
    qmi_rsp_if.source      rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    // the queue is split in two rings: the front ring holds the first
    // ceil(n/2) words, the back ring the rest, so the middle is the back head
    qmi_pkg::ring_op_t          f_op;
    qmi_pkg::ring_op_t          b_op;
    logic [qmi_pkg::DATA_W-1:0] f_wdata;
    logic [qmi_pkg::DATA_W-1:0] f_head;
    logic [qmi_pkg::DATA_W-1:0] b_head;
    logic [CW-1:0]              f_count;
    logic [CW-1:0]              b_count;
    logic [CW-1:0]              total;
    logic [CW-1:0]              total_after;
    logic                       balanced;
    logic                       full;
    logic                       accept;
    qmi_pkg::rsp_t              result;

    // output register and skid stage
    logic                       out_valid_reg;
    qmi_pkg::rsp_t              out_data_reg;
    logic                       skid_valid_reg;
    qmi_pkg::rsp_t              skid_data_reg;

    assign total    = f_count + b_count;
    // even count: both halves equal, so growth moves the middle word forward
    assign balanced = (f_count == b_count);
    assign full     = (total == CW'(CAPACITY));
    assign accept   = cmd.valid && cmd.ready;

    always_comb
    begin
        f_op                = '0;
        b_op                = '0;
        f_wdata             = cmd.value;
        result.popped_value = '0;
        result.status       = qmi_pkg::ST_OK;
        total_after         = total;
        case (cmd.action)
            qmi_pkg::ACT_PUSH_TAIL:
            begin
                if (full)
                begin
                    result.status = qmi_pkg::ST_FULL;
                end
                else
                begin
                    total_after = total + CW'(1);
                    if (balanced && (b_count == '0))
                    begin
                        // empty queue: the word lands straight in the front ring
                        f_op.push_tail = 1'b1;
                    end
                    else if (balanced)
                    begin
                        // append at back, shift back head to front tail
                        b_op.push_tail = 1'b1;
                        b_op.take_head = 1'b1;
                        f_op.push_tail = 1'b1;
                        f_wdata        = b_head;
                    end
                    else
                    begin
                        b_op.push_tail = 1'b1;
                    end
                end
            end
            qmi_pkg::ACT_PUSH_MID:
            begin
                if (full)
                begin
                    result.status = qmi_pkg::ST_FULL;
                end
                else
                begin
                    total_after = total + CW'(1);
                    if (balanced)
                    begin
                        // inserted word would move forward at once
                        f_op.push_tail = 1'b1;
                    end
                    else
                    begin
                        b_op.push_head = 1'b1;
                    end
                end
            end
            qmi_pkg::ACT_POP:
            begin
                if (f_count == '0)
                begin
                    result.status = qmi_pkg::ST_EMPTY;
                end
                else
                begin
                    total_after         = total - CW'(1);
                    result.popped_value = f_head;
                    f_op.take_head      = 1'b1;
                    if (balanced && (b_count != '0))
                    begin
                        b_op.take_head = 1'b1;
                        f_op.push_tail = 1'b1;
                        f_wdata        = b_head;
                    end
                end
            end
            default:
            begin
                // unused code: no change
            end
        endcase
        // entry count reported modulo 128
        result.entry_count = qmi_pkg::ENTRY_COUNT_W'(total_after);
        if (!accept)
        begin
            f_op = '0;
            b_op = '0;
        end
    end

    qmi_ring #(
        .CAPACITY (CAPACITY)
    ) u_front_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (f_op),
        .wdata      (f_wdata),
        .head_value (f_head),
        .count      (f_count)
    );

    qmi_ring #(
        .CAPACITY (CAPACITY)
    ) u_back_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (b_op),
        .wdata      (cmd.value),
        .head_value (b_head),
        .count      (b_count)
    );

    // response register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !rsp.ready)
        begin
            if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !rsp.ready)
        begin
            if (accept)
            begin
                skid_data_reg <= result;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign cmd.ready        = !skid_valid_reg;
    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = out_data_reg.popped_value;
    assign rsp.status       = out_data_reg.status;
    assign rsp.entry_count  = out_data_reg.entry_count;

endmodule

FILE: design/qmi_checker.sv
// ----------------------------------------------------------------------------
// qmi_checker
// port-level checks of the queue with middle insertion, bound to the top level
// ----------------------------------------------------------------------------
module qmi_checker #(
    parameter int CAPACITY = qmi_pkg::DEFAULT_CAPACITY
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  cmd_valid,
    input logic                                  cmd_ready,
    input logic                                  rsp_valid,
    input logic                                  rsp_ready,
    input logic signed [qmi_pkg::DATA_W-1:0]     popped_value,
    input qmi_pkg::status_t                      status,
    input logic [qmi_pkg::ENTRY_COUNT_W-1:0]     entry_count
);

    localparam int CAP_MOD = CAPACITY % 128;

    logic                              rsp_accept;
    logic                              have_last_reg;
    logic [qmi_pkg::ENTRY_COUNT_W-1:0] last_count_reg;

    assign rsp_accept = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_last_reg  <= 1'b0;
            last_count_reg <= '0;
        end
        else if (rsp_accept)
        begin
            have_last_reg  <= 1'b1;
            last_count_reg <= entry_count;
        end
    end

    // stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(popped_value)
                                    && $stable(status) && $stable(entry_count))
        else $error("response changed while stalled");

    // a word taken while the response stalls fills the skid, so ready drops
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && rsp_valid && !rsp_ready |=> !cmd_ready)
        else $error("skid full but command still ready");

    // pop on empty only with an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == qmi_pkg::ST_EMPTY) |->
            (popped_value == '0) && (entry_count == '0))
        else $error("empty status with data or nonzero count");

    // dropped push only at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == qmi_pkg::ST_FULL) |->
            (popped_value == '0)
            && (entry_count == qmi_pkg::ENTRY_COUNT_W'(CAP_MOD)))
        else $error("full status below capacity");

    // every word changes the count by at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_accept && have_last_reg |->
            (entry_count == last_count_reg)
            || (entry_count == last_count_reg + 7'd1)
            || (entry_count == last_count_reg - 7'd1))
        else $error("entry count jumped");

endmodule

bind queue_with_middle_insert qmi_checker #(
    .CAPACITY (CAPACITY)
) u_qmi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .popped_value (rsp.popped_value),
    .status       (rsp.status),
    .entry_count  (rsp.entry_count)
);
